>>> rtl/core/i64dec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i64dec_pkg: shared types and constants for the decimal text converter
// Holds the ASCII codes, the digit count helper and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package i64dec_pkg;

    // Default converted width and field widths fixed by the interface
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int IN_DATA_W       = 64;
    localparam int TEXT_W          = 8;

    // ASCII codes
    localparam logic [TEXT_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [TEXT_W-1:0] ASCII_NINE  = 8'h39;
    localparam logic [TEXT_W-1:0] ASCII_MINUS = 8'h2D;

    // BCD digit width and the double-dabble correction
    localparam int            BCD_W      = 4;
    localparam logic [BCD_W-1:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [BCD_W-1:0] BCD_ADJ     = 4'd3;

    // Request type codes
    localparam logic REQ_SIGNED   = 1'b0;
    localparam logic REQ_UNSIGNED = 1'b1;

    // Decimal digits of 2^width - 1: floor(width * log10(2)) + 1
    function automatic int dec_digits(input int width);
        return ((width * 1233) >> 12) + 1;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // capture a new value, clear BCD
        logic conv_step;    // one shift/add-3 step
        logic shift_digit;  // drop the top digit
        logic sel_sign;     // drive '-' on the output byte
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic conv_done;    // current step is the last conversion step
        logic top_zero;     // top BCD digit is zero
        logic last_digit;   // one digit left
        logic negative;     // value printed with a leading '-'
    } dp_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/i64dec_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i64dec_dp: conversion datapath
// Magnitude register, shift/add-3 BCD register and counters. Converts one bit
// per step, then shifts digits out of the top of the BCD register.
// ----------------------------------------------------------------------------
module i64dec_dp
    import i64dec_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 req_type,
    input  wire logic [IN_DATA_W-1:0] value_bits,
    input  wire dp_cmd_t              cmd,
    output dp_sts_t                   sts,
    output logic      [TEXT_W-1:0]    text_byte
);

    localparam int NUM_DIGITS = dec_digits(VALUE_WIDTH);
    localparam int BCD_BITS   = NUM_DIGITS * BCD_W;
    localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_BITS-1:0]    bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic                   neg_reg, neg_next;

    logic [VALUE_WIDTH-1:0] raw;
    logic                   raw_neg;
    logic [BCD_BITS-1:0]    bcd_adj;
    logic [BCD_W-1:0]       top_digit;

    assign raw     = value_bits[VALUE_WIDTH-1:0];
    assign raw_neg = (req_type == REQ_SIGNED) && raw[VALUE_WIDTH-1];

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*BCD_W +: BCD_W] >= BCD_ADJ_MIN) begin
                bcd_adj[i*BCD_W +: BCD_W] = bcd_reg[i*BCD_W +: BCD_W] + BCD_ADJ;
            end else begin
                bcd_adj[i*BCD_W +: BCD_W] = bcd_reg[i*BCD_W +: BCD_W];
            end
        end
    end

    // Next-state logic
    always_comb begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        neg_next     = neg_reg;
        if (cmd.load) begin
            neg_next     = raw_neg;
            mag_next     = raw_neg ? VALUE_WIDTH'(~raw + VALUE_WIDTH'(1)) : raw;
            bcd_next     = '0;
            bit_cnt_next = BIT_CNT_W'(VALUE_WIDTH - 1);
            dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
        end else if (cmd.conv_step) begin
            bcd_next     = {bcd_adj[BCD_BITS-2:0], mag_reg[VALUE_WIDTH-1]};
            mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
        end else if (cmd.shift_digit) begin
            bcd_next     = {bcd_reg[BCD_BITS-BCD_W-1:0], {BCD_W{1'b0}}};
            dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
        end
    end

    // Payload registers; meaningful only after a load
    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        neg_reg     <= neg_next;
    end

    // Status and output byte
    assign top_digit      = bcd_reg[BCD_BITS-1 -: BCD_W];
    assign sts.conv_done  = (bit_cnt_reg == '0);
    assign sts.top_zero   = (top_digit == '0);
    assign sts.last_digit = (dig_cnt_reg == DIG_CNT_W'(1));
    assign sts.negative   = neg_reg;
    assign text_byte      = cmd.sel_sign ? ASCII_MINUS
                                         : ASCII_ZERO + {{(TEXT_W-BCD_W){1'b0}}, top_digit};

endmodule
`default_nettype wire

>>> rtl/core/i64dec_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i64dec_ctrl: conversion controller
// Sequences load, conversion steps, leading-zero skip, sign beat and digit
// beats, and runs both stream handshakes.
// ----------------------------------------------------------------------------
module i64dec_ctrl
    import i64dec_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output logic         m_tlast,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;

    // State transitions and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tlast    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.conv_step = 1'b1;
                if (sts.conv_done) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (sts.top_zero && !sts.last_digit) begin
                    cmd.shift_digit = 1'b1;
                end else begin
                    state_next = sts.negative ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                m_tvalid     = 1'b1;
                cmd.sel_sign = 1'b1;
                if (m_tready) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                m_tlast  = sts.last_digit;
                if (m_tready) begin
                    if (sts.last_digit) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.shift_digit = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/int64_to_decimal_ascii.sv
`default_nettype none
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii: integer to decimal ASCII text
// Streams the decimal text of one integer per input beat, one character per
// output beat, most significant digit first.
// ----------------------------------------------------------------------------
// Each input beat carries an integer (low VALUE_WIDTH bits of s_tdata) and a
// request type on s_tuser (0 signed, 1 unsigned). The block returns its
// decimal text without leading zeros, '-' first for a negative signed value
// (the most negative value prints in full), with m_tlast on the final digit.
// One number is handled at a time: after a beat is taken the shift/add-3
// converter shifts in all VALUE_WIDTH bits (one bit per cycle), the
// leading-zero skip drops one zero at a time, then one beat per character
// goes out; s_tready is high again the cycle after the last character is
// taken.
module int64_to_decimal_ascii
    import i64dec_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,   // [63:0] value_bits
    input  wire logic                 s_tuser,   // [0] req_type
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [TEXT_W-1:0]    m_tdata,   // [7:0] text_byte
    output logic                      m_tlast    // is_last
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Controller
    i64dec_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    i64dec_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .req_type   (s_tuser),
        .value_bits (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .text_byte  (m_tdata)
    );

    // Input is never taken while a character is on offer
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while output valid");

    // A taken beat starts a conversion
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready held after accept");

    // Every output byte is '-' or a digit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata == ASCII_MINUS) ||
                      ((m_tdata >= ASCII_ZERO) && (m_tdata <= ASCII_NINE))))
        else $error("output byte not a sign or digit");

    // The final character is a digit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata != ASCII_MINUS))
        else $error("sign flagged as last");

endmodule
`default_nettype wire
